[design/ced_pkg.sv]
// Shared types and constants for the color error diffusion halftoner.
package ced_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_VALUE_BITS = 20;
    localparam int MAX_HEIGHT     = 1024;
    localparam int QUEUE_DEPTH    = 4;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0]     RESET_SIZE       = 11'd256;
    localparam int MIN_SIZE = 3;

    // Ink values are held in units of 1/(255*256) of full ink.
    localparam int FULL_INK = 65280;
    localparam int INK_MID  = 32640;

    localparam logic [7:0] BYTE_WHITE = 8'd255;
    localparam logic [7:0] BYTE_BLACK = 8'd0;
    localparam int RGB_W = 24;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_pix_out;

    // Classification of one pixel, made by the front and acted on by the back.
    typedef struct packed {
        logic interior;
        logic edge_write;
        logic row_one;
        logic row_start;
        logic frame_start;
        logic frame_end;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

endpackage

[design/color_error_diffusion_halftone_unit.sv]
// Top level of the color error diffusion halftoner.
//
// Pixels enter on the input channel (i_in_valid / o_in_ready) in raster order,
// one item per pixel, with frame_start set on the first pixel of a frame.
// Each pixel leaves as one halftoned item on the output channel (o_out_valid /
// i_out_ready); every byte is 0 or 255 and frame_end marks the last pixel.
// Frame size is set through the write port: index 0 is the width, index 1 the
// height, both clamped to at least 3; write them only while the block is idle.
// Throughput is one pixel per clock while the receiver keeps i_out_ready high.
// The right-neighbor error loop closes combinationally, and the row error memory
// does at most one read and one write a cycle. From input accept to output
// valid, an item passes the four-entry queue, then the read stage, in which the
// registered memory read feeds the arithmetic that loads the output register.
// When the receiver stalls, the output register holds its item, the queue
// fills and o_in_ready falls once all four entries are taken.
// Reset restores the 256 by 256 size, clears the position, the carries and the
// memory fill count, so the row error memory reads as zero until written.
module color_error_diffusion_halftone_unit #(
    parameter int MAX_WIDTH  = ced_pkg::DEF_MAX_WIDTH,
    parameter int VALUE_BITS = ced_pkg::DEF_VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ced_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ced_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ced_pkg::t_pix_in                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ced_pkg::t_pix_out               o_out_data
);
    import ced_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = FLAGS_W + CW + RGB_W;

    logic             push;
    t_flags           f_flags;
    logic [CW-1:0]    f_col;
    logic [RGB_W-1:0] f_rgb;
    logic [QW-1:0]    q_wdata;
    logic [QW-1:0]    q_rdata;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    t_flags           q_flags;
    logic [CW-1:0]    q_col;
    logic [RGB_W-1:0] q_rgb;

    assign o_in_ready = !q_full;
    assign push       = i_in_valid && o_in_ready;

    ced_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_pix      (i_in_data),
        .o_flags    (f_flags),
        .o_col      (f_col),
        .o_rgb      (f_rgb)
    );

    assign q_wdata = {f_flags, f_col, f_rgb};

    ced_queue #(
        .DW    (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign q_flags = t_flags'(q_rdata[QW-1 -: FLAGS_W]);
    assign q_col   = q_rdata[RGB_W +: CW];
    assign q_rgb   = q_rdata[RGB_W-1:0];

    ced_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_flags   (q_flags),
        .i_q_col     (q_col),
        .i_q_rgb     (q_rgb),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

    // Every channel of a result is fully inked or blank.
    a_binary_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.red_out == BYTE_WHITE || o_out_data.red_out == BYTE_BLACK) &&
            (o_out_data.green_out == BYTE_WHITE || o_out_data.green_out == BYTE_BLACK) &&
            (o_out_data.blue_out == BYTE_WHITE || o_out_data.blue_out == BYTE_BLACK))
        else $error("halftone result byte is neither 0 nor 255");

    // The last pixel of a frame lies on the border and is always white.
    a_frame_end_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_end) |->
            (o_out_data.red_out == BYTE_WHITE) && (o_out_data.green_out == BYTE_WHITE) &&
            (o_out_data.blue_out == BYTE_WHITE))
        else $error("frame end pixel is not white");

    // Nothing can be pending on the output after a reset cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // An empty queue cannot hand an item to the back part.
    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

[design/ced_front.sv]
// Front part: size registers, raster position tracking and pixel classification.
module ced_front #(
    parameter int MAX_WIDTH = ced_pkg::DEF_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ced_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ced_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_push,
    input  ced_pkg::t_pix_in                    i_pix,
    output ced_pkg::t_flags                     o_flags,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_col,
    output logic [ced_pkg::RGB_W-1:0]           o_rgb
);
    import ced_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = ((WW > CFG_W) ? WW : CFG_W) + 1;
    localparam int HW    = ((RW + 1 > CFG_W) ? RW + 1 : CFG_W) + 1;

    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;

    logic [CMP_W-1:0] w_ext;
    logic [CMP_W-1:0] w_eff;
    logic [HW-1:0]    h_ext;
    logic [HW-1:0]    h_eff;
    logic [CW-1:0]    col;
    logic [RW-1:0]    row;
    logic             last_col;
    logic             last_row;

    always_comb begin
        w_ext = CMP_W'(r_cfg_w);
        if (w_ext < CMP_W'(MIN_SIZE)) begin
            w_eff = CMP_W'(MIN_SIZE);
        end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        h_ext = HW'(r_cfg_h);
        if (h_ext < HW'(MIN_SIZE)) begin
            h_eff = HW'(MIN_SIZE);
        end else if (h_ext > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
    end

    // A frame start forces the position back to the top left corner.
    assign col = i_pix.frame_start ? '0 : r_col;
    assign row = i_pix.frame_start ? '0 : r_row;

    assign last_col = (CMP_W'(col) + CMP_W'(1)) >= w_eff;
    assign last_row = (HW'(row) + HW'(1)) >= h_eff;

    always_comb begin
        o_flags.interior    = (row != '0) && !last_row && (col != '0) && !last_col;
        o_flags.edge_write  = last_col && (row != '0) && !last_row && (col != '0);
        o_flags.row_one     = (row == RW'(1));
        o_flags.row_start   = (col == '0);
        o_flags.frame_start = i_pix.frame_start;
        o_flags.frame_end   = last_col && last_row;
    end

    assign o_col = col;
    assign o_rgb = {i_pix.red_in, i_pix.green_in, i_pix.blue_in};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RESET_SIZE;
            r_cfg_h <= RESET_SIZE;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                    REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : row + RW'(1);
                end else begin
                    r_col <= col + CW'(1);
                    r_row <= row;
                end
            end
        end
    end

endmodule

[design/ced_queue.sv]
// Short queue that decouples the classifying front from the arithmetic back.
module ced_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = ced_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);
    import ced_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
    assign n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + NW'(1);
                2'b01:   r_count <= r_count - NW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/ced_back.sv]
// Back part: row error memory, threshold against the ink cube and error spreading.
module ced_back #(
    parameter int MAX_WIDTH  = ced_pkg::DEF_MAX_WIDTH,
    parameter int VALUE_BITS = ced_pkg::DEF_VALUE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  ced_pkg::t_flags                i_q_flags,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_q_col,
    input  logic [ced_pkg::RGB_W-1:0]      i_q_rgb,
    output logic                           o_q_pop,
    output logic                           o_out_valid,
    output ced_pkg::t_pix_out              o_out_data,
    input  logic                           i_out_ready
);
    import ced_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int FW     = $clog2(MAX_WIDTH + 1);
    localparam int VB     = VALUE_BITS;
    localparam int SW     = VB + 3;
    localparam int EW     = VB + 2;
    localparam int MW     = EW + 3;
    localparam int WORD_W = 3 * VB;

    localparam logic signed [VB-1:0] VMAX     = {1'b0, {(VB - 1){1'b1}}};
    localparam logic signed [VB-1:0] VMIN     = {1'b1, {(VB - 1){1'b0}}};
    localparam logic signed [MW-1:0] LIM_HI   = MW'(VMAX);
    localparam logic signed [MW-1:0] LIM_LO   = MW'(VMIN);
    localparam logic signed [VB-1:0] MID_V    = VB'(INK_MID);
    localparam logic signed [EW-1:0] FULL_E   = EW'(FULL_INK);

    function automatic logic signed [VB-1:0] sat_v(input logic signed [MW-1:0] x);
        logic signed [VB-1:0] res;
        if (x > LIM_HI) begin
            res = VMAX;
        end else if (x < LIM_LO) begin
            res = VMIN;
        end else begin
            res = x[VB-1:0];
        end
        return res;
    endfunction

    // Row error memory, one word per column holding all three channels.
    logic [WORD_W-1:0] r_mem [MAX_WIDTH];
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_ok;
    logic [FW-1:0]     r_fill;

    logic              r_s1_valid;
    t_flags            r_s1_flags;
    logic [CW-1:0]     r_s1_col;
    logic [RGB_W-1:0]  r_s1_rgb;

    logic signed [VB-1:0] r_rc  [3];
    logic signed [VB-1:0] r_bp0 [3];
    logic signed [VB-1:0] r_bp1 [3];

    logic              r_out_valid;
    t_pix_out          r_out_data;

    logic              s1_fire;
    logic              mem_we;
    logic [CW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_word;
    logic              use_below;

    logic [7:0]           byte_in [3];
    logic signed [SW-1:0] v_s     [3];
    logic signed [VB-1:0] below   [3];
    logic signed [SW-1:0] sum     [3];
    logic signed [VB-1:0] x       [3];
    logic                 ink     [3];
    logic signed [EW-1:0] e       [3];
    logic signed [MW-1:0] e_w     [3];
    logic signed [MW-1:0] s7      [3];
    logic signed [MW-1:0] s5      [3];
    logic signed [MW-1:0] s3      [3];
    logic signed [VB-1:0] rc_n    [3];
    logic signed [VB-1:0] bp0_n   [3];
    logic signed [VB-1:0] bp1_n   [3];
    logic signed [VB-1:0] wr_v    [3];
    logic [7:0]           byte_out[3];

    assign s1_fire = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop = i_q_valid && (!r_s1_valid || s1_fire);

    assign byte_in[0] = r_s1_rgb[23:16];
    assign byte_in[1] = r_s1_rgb[15:8];
    assign byte_in[2] = r_s1_rgb[7:0];

    // On the first interior row, and for columns not yet written in this frame,
    // the error from the row above reads as zero.
    assign use_below = r_rd_ok && !r_s1_flags.row_one;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            v_s[ch]   = $signed(SW'({~byte_in[ch], 8'h00}));
            below[ch] = use_below ? $signed(r_rd_data[ch*VB +: VB]) : '0;
            sum[ch]   = v_s[ch] + SW'(r_rc[ch]) + SW'(below[ch]);
            x[ch]     = sat_v(MW'(sum[ch]));
            // Squared distance separates by channel; a tie keeps the ink off.
            ink[ch]   = x[ch] > MID_V;
            e[ch]     = EW'(x[ch]) - (ink[ch] ? FULL_E : '0);
            e_w[ch]   = MW'(e[ch]);
            s7[ch]    = ((e_w[ch] <<< 3) - e_w[ch]) >>> 4;
            s5[ch]    = ((e_w[ch] <<< 2) + e_w[ch]) >>> 4;
            s3[ch]    = ((e_w[ch] <<< 1) + e_w[ch]) >>> 4;
            rc_n[ch]  = sat_v(s7[ch]);
            bp1_n[ch] = sat_v(e_w[ch] >>> 4);
            bp0_n[ch] = sat_v(MW'(r_bp1[ch]) + s5[ch]);
            wr_v[ch]  = sat_v(MW'(r_bp0[ch]) + s3[ch]);
            byte_out[ch] = (r_s1_flags.interior && ink[ch]) ? BYTE_BLACK : BYTE_WHITE;
        end
    end

    assign mem_we  = s1_fire && (r_s1_flags.interior || r_s1_flags.edge_write);
    assign wr_addr = r_s1_col - CW'(1);

    always_comb begin
        wr_word = '0;
        for (int ch = 0; ch < 3; ch++) begin
            wr_word[ch*VB +: VB] = r_s1_flags.interior ? wr_v[ch] : r_bp0[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_word;
        end
        if (o_q_pop) begin
            r_rd_data <= r_mem[i_q_col];
        end
    end

    // Payload of the read stage and the output register.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_flags <= i_q_flags;
            r_s1_col   <= i_q_col;
            r_s1_rgb   <= i_q_rgb;
            r_rd_ok    <= FW'(i_q_col) < r_fill;
        end
        if (s1_fire) begin
            r_out_data.red_out   <= byte_out[0];
            r_out_data.green_out <= byte_out[1];
            r_out_data.blue_out  <= byte_out[2];
            r_out_data.frame_end <= r_s1_flags.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            for (int ch = 0; ch < 3; ch++) begin
                r_rc[ch]  <= '0;
                r_bp0[ch] <= '0;
                r_bp1[ch] <= '0;
            end
        end else begin
            if (o_q_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (s1_fire) begin
                // Columns written since the frame start always form a prefix.
                if (r_s1_flags.frame_start) begin
                    r_fill <= '0;
                end else if (mem_we && (FW'(wr_addr) == r_fill)) begin
                    r_fill <= r_fill + FW'(1);
                end

                for (int ch = 0; ch < 3; ch++) begin
                    if (r_s1_flags.row_start) begin
                        r_rc[ch]  <= '0;
                        r_bp0[ch] <= '0;
                        r_bp1[ch] <= '0;
                    end else if (r_s1_flags.interior) begin
                        r_rc[ch]  <= rc_n[ch];
                        r_bp0[ch] <= bp0_n[ch];
                        r_bp1[ch] <= bp1_n[ch];
                    end
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
